// File: rtl/teabc_pkg.sv
package teabc_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_KEYS    = 4;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned ROUNDS_DEF  = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0_IDX = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1_IDX = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2_IDX = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3_IDX = 8'd3;

    localparam logic [WORD_W-1:0] KEY_WORD_0_RST = 32'd371;
    localparam logic [WORD_W-1:0] KEY_WORD_1_RST = 32'd215;
    localparam logic [WORD_W-1:0] KEY_WORD_2_RST = 32'd11;
    localparam logic [WORD_W-1:0] KEY_WORD_3_RST = 32'd12;

    typedef enum logic {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } kind_t;

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

    // one block in flight
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } block_t;

    // delta * count mod 2^32, evaluated at elaboration only
    function automatic logic [WORD_W-1:0] sched_sum(input int unsigned count);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(count);
        return prod[WORD_W-1:0];
    endfunction

endpackage

// File: rtl/teabc_half_round.sv
module teabc_half_round
    import teabc_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF,
    parameter int unsigned STEP   = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  key_set_t keys,
    input  logic     valid_in,
    input  block_t   data_in,
    output logic     ready_in,
    output logic     valid_out,
    output block_t   data_out,
    input  logic     ready_out
);

    localparam int unsigned ROUND_IDX = STEP / 2;
    localparam logic        STEP_ODD  = 1'(STEP % 2);
    localparam logic [WORD_W-1:0] ENC_SUM = sched_sum(ROUND_IDX + 1);
    localparam logic [WORD_W-1:0] DEC_SUM = sched_sum(ROUNDS - ROUND_IDX);

    logic              valid_reg;
    block_t            data_reg;
    block_t            data_next;
    logic              upd_first;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] dst_new;

    // encrypt: even steps update the first word; decrypt runs the halves reversed
    always_comb begin
        upd_first = (data_in.kind == kind_t'(STEP_ODD));
        src       = upd_first ? data_in.second_word : data_in.first_word;
        dst       = upd_first ? data_in.first_word  : data_in.second_word;
        ka        = upd_first ? keys[0] : keys[2];
        kb        = upd_first ? keys[1] : keys[3];
        sum       = (data_in.kind == KIND_DECRYPT) ? DEC_SUM : ENC_SUM;
        mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
        dst_new   = (data_in.kind == KIND_DECRYPT) ? (dst - mix) : (dst + mix);
        data_next = data_in;
        if (upd_first) begin
            data_next.first_word = dst_new;
        end else begin
            data_next.second_word = dst_new;
        end
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_in) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_in && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// File: rtl/tea_block_cipher_unit.sv
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | s_kind, s_text_first_word, s_text_second_word
// m_      | out       | m_valid / m_ready   | m_result_first_word, m_result_second_word
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (key words 0..3)
//
// One block enters per cycle while s_ready is high, with one pipeline stage per
// half-round, each stage two 32-bit adds deep.
// The last stage register is the output register.
// Reset clears every stage valid bit and loads the key words with their defaults.
// A stall only holds stages that are full and blocked; empty stages keep filling.
// cfg_ready is always high; writes to indexes above three are dropped.
module tea_block_cipher_unit
    import teabc_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic [WORD_W-1:0]      s_text_first_word,
    input  logic [WORD_W-1:0]      s_text_second_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [WORD_W-1:0]      m_result_first_word,
    output logic [WORD_W-1:0]      m_result_second_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    key_set_t key_reg;
    block_t   link  [STAGES+1];
    logic     vld   [STAGES+1];
    logic     rdy   [STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0] <= KEY_WORD_0_RST;
            key_reg[1] <= KEY_WORD_1_RST;
            key_reg[2] <= KEY_WORD_2_RST;
            key_reg[3] <= KEY_WORD_3_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                KEY_WORD_0_IDX: key_reg[0] <= cfg_data;
                KEY_WORD_1_IDX: key_reg[1] <= cfg_data;
                KEY_WORD_2_IDX: key_reg[2] <= cfg_data;
                KEY_WORD_3_IDX: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign link[0].kind        = kind_t'(s_kind);
    assign link[0].first_word  = s_text_first_word;
    assign link[0].second_word = s_text_second_word;
    assign vld[0]              = s_valid;
    assign s_ready             = rdy[0];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        teabc_half_round #(
            .ROUNDS (ROUNDS),
            .STEP   (i)
        ) u_half_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .keys      (key_reg),
            .valid_in  (vld[i]),
            .data_in   (link[i]),
            .ready_in  (rdy[i]),
            .valid_out (vld[i+1]),
            .data_out  (link[i+1]),
            .ready_out (rdy[i+1])
        );
    end

    assign rdy[STAGES]          = m_ready;
    assign m_valid              = vld[STAGES];
    assign m_result_first_word  = link[STAGES].first_word;
    assign m_result_second_word = link[STAGES].second_word;

    // a taken output always frees the whole chain
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although output is taken");

    a_ready_when_empty_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_key_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == KEY_WORD_2_IDX) |=> key_reg[2] == $past(cfg_data))
        else $error("key word 2 write lost");

endmodule

// File: tb/testbench.sv
module testbench;
    import teabc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY      = 2 * ROUNDS_DEF;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // indexes past the key words; the block must drop these writes
    localparam logic [CFG_INDEX_W-1:0] UNUSED_IDX_LOW  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_IDX_HIGH = 8'hFF;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } word_pair_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [WORD_W-1:0]      data;
    } key_write_t;

    logic                   aclk                 = 1'b0;
    logic                   aresetn              = 1'b0;
    logic                   s_valid              = 1'b0;
    logic                   s_ready;
    logic                   s_kind               = KIND_ENCRYPT;
    logic [WORD_W-1:0]      s_text_first_word    = '0;
    logic [WORD_W-1:0]      s_text_second_word   = '0;
    logic                   m_valid;
    logic                   m_ready              = 1'b0;
    logic [WORD_W-1:0]      m_result_first_word;
    logic [WORD_W-1:0]      m_result_second_word;
    logic                   cfg_valid            = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index            = '0;
    logic [WORD_W-1:0]      cfg_data             = '0;

    block_t     block_q[$];
    key_write_t key_write_q[$];
    word_pair_t cipher_out_q[$];
    key_set_t   key_model;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned encrypt_count = 0;
    int unsigned decrypt_count = 0;
    int unsigned result_count = 0;
    int unsigned key_write_count = 0;

    tea_block_cipher_unit DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_kind               (s_kind),
        .s_text_first_word    (s_text_first_word),
        .s_text_second_word   (s_text_second_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_first_word  (m_result_first_word),
        .m_result_second_word (m_result_second_word),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] feistel_mix(
        logic [WORD_W-1:0] x,
        logic [WORD_W-1:0] sum,
        logic [WORD_W-1:0] ka,
        logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        a = (x << 4) + ka;
        b = x + sum;
        c = (x >> 5) + kb;
        return a ^ b ^ c;
    endfunction

    function automatic word_pair_t tea_transform(block_t blk, key_set_t keys);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        word_pair_t        res;
        v0 = blk.first_word;
        v1 = blk.second_word;
        if (blk.kind == KIND_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < ROUNDS_DEF; r++) begin
                sum = sum + TEA_DELTA;
                v0  = v0 + feistel_mix(v1, sum, keys[0], keys[1]);
                v1  = v1 + feistel_mix(v0, sum, keys[2], keys[3]);
            end
        end else begin
            // start sum wraps mod 2^32 in a 32-bit product
            sum = TEA_DELTA * WORD_W'(ROUNDS_DEF);
            for (int r = 0; r < ROUNDS_DEF; r++) begin
                v1  = v1 - feistel_mix(v0, sum, keys[2], keys[3]);
                v0  = v0 - feistel_mix(v1, sum, keys[0], keys[1]);
                sum = sum - TEA_DELTA;
            end
        end
        res.first_word  = v0;
        res.second_word = v1;
        return res;
    endfunction

    // block driver
    always @(posedge aclk) begin
        block_t blk;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                blk.kind        = kind_t'(s_kind);
                blk.first_word  = s_text_first_word;
                blk.second_word = s_text_second_word;
                cipher_out_q.push_back(tea_transform(blk, key_model));
                if (blk.kind == KIND_ENCRYPT) encrypt_count++;
                else decrypt_count++;
            end
            if (!s_valid || s_ready) begin
                if (block_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    blk = block_q.pop_front();
                    s_valid            <= 1'b1;
                    s_kind             <= blk.kind;
                    s_text_first_word  <= blk.first_word;
                    s_text_second_word <= blk.second_word;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // key write driver, also keeps the key copy used for prediction
    always @(posedge aclk) begin
        key_write_t kw;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            key_model[0] = KEY_WORD_0_RST;
            key_model[1] = KEY_WORD_1_RST;
            key_model[2] = KEY_WORD_2_RST;
            key_model[3] = KEY_WORD_3_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < NUM_KEYS) key_model[cfg_index[1:0]] = cfg_data;
                key_write_count++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (key_write_q.size() != 0) begin
                    kw = key_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= kw.index;
                    cfg_data  <= kw.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge aclk) begin
        word_pair_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (cipher_out_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none actual %h %h", $realtime,
                             m_result_first_word, m_result_second_word);
                end else begin
                    want = cipher_out_q.pop_front();
                    if (m_result_first_word !== want.first_word) begin
                        mismatch_count++;
                        $display("%0t: result_first_word expected %h actual %h",
                                 $realtime, want.first_word, m_result_first_word);
                    end
                    if (m_result_second_word !== want.second_word) begin
                        mismatch_count++;
                        $display("%0t: result_second_word expected %h actual %h",
                                 $realtime, want.second_word, m_result_second_word);
                    end
                end
            end
            if (hold_served != hold_req) begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, cipher_out_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (block_q.size() != 0 || s_valid || cipher_out_q.size() != 0 ||
                   key_write_q.size() != 0 || cfg_valid);
    endtask

    task automatic load_keys(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1,
                             logic [WORD_W-1:0] k2, logic [WORD_W-1:0] k3);
        key_write_q.push_back('{KEY_WORD_0_IDX, k0});
        key_write_q.push_back('{KEY_WORD_1_IDX, k1});
        key_write_q.push_back('{KEY_WORD_2_IDX, k2});
        key_write_q.push_back('{KEY_WORD_3_IDX, k3});
        wait_drained();
    endtask

    task automatic push_block(kind_t k, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1);
        block_q.push_back('{k, w0, w1});
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly random blocks; some decrypts take a ciphertext under the live keys
    task automatic push_random(int unsigned n);
        block_t     blk;
        word_pair_t ct;
        for (int unsigned i = 0; i < n; i++) begin
            blk.kind        = kind_t'($urandom_range(1));
            blk.first_word  = pick_word();
            blk.second_word = pick_word();
            if (blk.kind == KIND_DECRYPT && $urandom_range(1)) begin
                blk.kind        = KIND_ENCRYPT;
                ct              = tea_transform(blk, key_model);
                blk.kind        = KIND_DECRYPT;
                blk.first_word  = ct.first_word;
                blk.second_word = ct.second_word;
            end
            block_q.push_back(blk);
        end
    endtask

    task automatic push_directed();
        push_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_block(KIND_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_block(KIND_ENCRYPT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_block(KIND_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset keys, directed blocks back to back
        push_directed();
        wait_drained();

        // all-zero key, then all-ones key with writes to unused indexes
        load_keys('0, '0, '0, '0);
        push_directed();
        push_random(150);
        wait_drained();

        key_write_q.push_back('{UNUSED_IDX_LOW, 32'h1234_5678});
        key_write_q.push_back('{UNUSED_IDX_HIGH, '1});
        load_keys('1, '1, '1, '1);
        key_write_q.push_back('{UNUSED_IDX_HIGH, '0});
        wait_drained();
        send_idle_pct = 70;
        push_random(150);
        wait_drained();

        load_keys($urandom, $urandom, $urandom, $urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        push_random(150);
        wait_drained();

        load_keys(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        push_random(150);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        load_keys($urandom, $urandom, $urandom, $urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        push_random(200);
        wait_drained();

        // short bursts, sender waits for the pipe to empty between them
        load_keys($urandom, $urandom, $urandom, $urandom);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        for (int b = 0; b < 5; b++) begin
            push_random(20);
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (LATENCY + 16) @(posedge aclk);

        $display("covered %0d encrypt and %0d decrypt blocks, %0d results, %0d key writes",
                 encrypt_count, decrypt_count, result_count, key_write_count);
        $display("key sets: reset, zero, ones, patterned, random; idle, stall and hold-off");
        if (mismatch_count == 0 && cipher_out_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: tea_block_cipher_unit.f
rtl/teabc_pkg.sv
rtl/teabc_half_round.sv
rtl/tea_block_cipher_unit.sv
tb/testbench.sv
